// ===== hdl/csv_record_tokenizer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CSV record tokenizer assertion macros
// Clocked property wrappers shared by the tokenizer's checking code.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_RECORD_TOKENIZER_UNIT_ASSERT_SVH

// check outside reset
`define CSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds while reset is applied
`define CSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/csv_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Types, constants and per-byte parsing functions of the CSV tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  localparam int MaxColumns = 64;
  localparam int ColW       = $clog2(MaxColumns + 1);
  localparam int OutColW    = 6;
  localparam int BomLen     = 3;
  localparam int NumSlots   = 5;
  localparam int QueueDepth = 4;

  localparam int SlotByte    = BomLen - 1;
  localparam int SlotRecord  = BomLen;
  localparam int SlotDefault = BomLen + 1;

  localparam logic [7:0] QuoteByte     = 8'h22;
  localparam logic [7:0] CrByte        = 8'h0D;
  localparam logic [7:0] LfByte        = 8'h0A;
  localparam logic [7:0] CommaByte     = 8'h2C;
  localparam logic [7:0] SemicolonByte = 8'h3B;
  localparam logic [7:0] TabByte       = 8'h09;

  localparam logic [1:0] SepComma     = 2'd0;
  localparam logic [1:0] SepSemicolon = 2'd1;
  localparam logic [1:0] SepTab       = 2'd2;

  typedef enum logic [1:0] {
    KindData          = 2'd0,
    KindFieldEnd      = 2'd1,
    KindRecordEnd     = 2'd2,
    KindDefaultHeader = 2'd3
  } item_kind_e;

  typedef logic [ColW-1:0]    col_t;
  typedef logic [OutColW-1:0] out_col_t;

  typedef struct packed {
    logic       inside_quotes;
    logic       quote_pending;
    logic       line_has_content;
    logic [1:0] bom_held;
    logic       bom_done;
    col_t       field_index;
    col_t       header_width;
    logic       header_complete;
    logic       overflow_seen;
  } state_t;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data_byte;
    out_col_t    column;
    logic        in_header;
    out_col_t    pad_fields;
    logic        too_many;
  } res_t;

  typedef struct packed {
    state_t st;
    logic   vld;
    res_t   res;
  } step_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    res_t [NumSlots-1:0] slots;
  } bundle_t;

  function automatic logic [7:0] sep_byte(logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      SepSemicolon: b = SemicolonByte;
      SepTab:       b = TabByte;
      default:      b = CommaByte;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bom_byte(logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      default: b = 8'hBF;
    endcase
    return b;
  endfunction

  function automatic res_t make_res(item_kind_e kind, logic [7:0] b, col_t col,
                                    logic hdr, col_t pad, logic ovf);
    res_t r;
    r.kind       = kind;
    r.data_byte  = b;
    r.column     = OutColW'(col);
    r.in_header  = hdr;
    r.pad_fields = OutColW'(pad);
    r.too_many   = ovf;
    return r;
  endfunction

  function automatic col_t col_limit(state_t s);
    return s.header_complete ? s.header_width : ColW'(MaxColumns);
  endfunction

  function automatic step_t put_data(state_t s, logic [7:0] b);
    step_t r;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    if (s.field_index < col_limit(s)) begin
      r.vld = 1'b1;
      r.res = make_res(KindData, b, s.field_index, !s.header_complete, '0,
                       s.overflow_seen);
    end
    return r;
  endfunction

  function automatic step_t end_field(state_t s);
    step_t       r;
    col_t        lim;
    logic [ColW:0] nxt;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    lim   = col_limit(s);
    nxt   = {1'b0, s.field_index} + (ColW + 1)'(1);
    if (nxt < {1'b0, lim}) begin
      r.vld = 1'b1;
      r.res = make_res(KindFieldEnd, '0, s.field_index, !s.header_complete, '0,
                       s.overflow_seen);
      r.st.field_index = nxt[ColW-1:0];
    end else begin
      if (!s.header_complete) r.st.overflow_seen = 1'b1;
      r.st.field_index = lim;
    end
    return r;
  endfunction

  function automatic step_t end_record(state_t s);
    step_t r;
    col_t  lim;
    col_t  col;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    lim   = col_limit(s);
    col   = (s.field_index < lim) ? s.field_index : lim - ColW'(1);
    if (s.line_has_content) begin
      r.vld = 1'b1;
      if (!s.header_complete) begin
        r.st.header_width    = col + ColW'(1);
        r.st.header_complete = 1'b1;
        r.res = make_res(KindRecordEnd, '0, col, 1'b1, '0, s.overflow_seen);
      end else begin
        r.res = make_res(KindRecordEnd, '0, col, 1'b0,
                         s.header_width - ColW'(1) - col, s.overflow_seen);
      end
    end
    r.st.field_index      = '0;
    r.st.line_has_content = 1'b0;
    return r;
  endfunction

  function automatic step_t parse_byte(state_t s, logic [7:0] b, logic [7:0] sep);
    step_t r;
    logic  open;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    open  = 1'b1;
    if (s.quote_pending) begin
      r.st.quote_pending = 1'b0;
      if (b == QuoteByte) begin
        r    = put_data(r.st, QuoteByte);
        open = 1'b0;
      end else begin
        r.st.inside_quotes = 1'b0;
      end
    end else if (s.inside_quotes) begin
      open = 1'b0;
      if (b == QuoteByte) r.st.quote_pending = 1'b1;
      else r = put_data(r.st, b);
    end
    if (open) begin
      if (b == QuoteByte) begin
        r.st.inside_quotes    = 1'b1;
        r.st.line_has_content = 1'b1;
      end else if (b == sep) begin
        r = end_field(r.st);
        r.st.line_has_content = 1'b1;
      end else if (b == CrByte) begin
        r.vld = 1'b0;
      end else if (b == LfByte) begin
        r = end_record(r.st);
      end else begin
        r = put_data(r.st, b);
        r.st.line_has_content = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/csv_tok_if.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer channels
// Valid/ready channels for text bytes, results and the separator register.
// ----------------------------------------------------------------------------
interface csv_tok_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, has_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, has_byte, end_of_text, output ready);
endinterface

interface csv_tok_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] data_byte;
  logic [5:0] column;
  logic       in_header;
  logic [5:0] pad_fields;
  logic       too_many_columns;
  logic       last;

  modport source (output valid, item_kind, data_byte, column, in_header, pad_fields,
                  too_many_columns, last, input ready);
  modport sink (input valid, item_kind, data_byte, column, in_header, pad_fields,
                too_many_columns, last, output ready);
endinterface

interface csv_tok_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] separator_select;

  modport source (output valid, separator_select, input ready);
  modport sink (input valid, separator_select, output ready);
endinterface

// ===== hdl/csv_tok_front.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer front end
// Accepts text requests, tracks quoting and byte order mark, builds result bundles.
// ----------------------------------------------------------------------------
module csv_tok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  csv_tok_text_if.sink        text_i,
  csv_tok_cfg_if.sink         cfg_i,
  output logic                push_o,
  output csv_tok_pkg::bundle_t bundle_o,
  input  logic                push_ready_i
);
  import csv_tok_pkg::*;

  state_t              state_q, state_d;
  logic [1:0]          sep_q;
  state_t              st;
  step_t               r;
  logic [7:0]          sep;
  logic [1:0]          h;
  logic [1:0]          n_held;
  logic                consumed;
  logic                need_replay;
  logic                accept;
  logic [NumSlots-1:0] slot_vld;
  res_t [NumSlots-1:0] slot_res;

  assign text_i.ready = push_ready_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = text_i.valid && push_ready_i;

  always_comb begin
    st          = state_q;
    sep         = sep_byte(sep_q);
    slot_vld    = '0;
    slot_res    = '0;
    consumed    = 1'b0;
    need_replay = 1'b0;
    h           = (state_q.bom_held == 2'd3) ? 2'd2 : state_q.bom_held;
    r           = '0;
    if (text_i.has_byte && !st.bom_done) begin
      if (text_i.text_byte == bom_byte(h)) begin
        consumed = 1'b1;
        if (h == 2'(BomLen - 1)) begin
          st.bom_held = '0;
          st.bom_done = 1'b1;
        end else begin
          st.bom_held = h + 2'd1;
        end
      end else begin
        need_replay = 1'b1;
      end
    end
    if (need_replay || (text_i.end_of_text && !st.bom_done)) begin
      n_held = st.bom_held;
      for (int i = 0; i < BomLen - 1; i++) begin
        if (2'(i) < n_held) begin
          r           = parse_byte(st, bom_byte(2'(i)), sep);
          st          = r.st;
          slot_vld[i] = r.vld;
          slot_res[i] = r.res;
        end
      end
      st.bom_held = '0;
      st.bom_done = 1'b1;
    end else begin
      n_held = '0;
    end
    if (text_i.has_byte && !consumed) begin
      r                  = parse_byte(st, text_i.text_byte, sep);
      st                 = r.st;
      slot_vld[SlotByte] = r.vld;
      slot_res[SlotByte] = r.res;
    end
    if (text_i.end_of_text) begin
      if (st.quote_pending) begin
        st.quote_pending = 1'b0;
        st.inside_quotes = 1'b0;
      end
      r                    = end_record(st);
      st                   = r.st;
      slot_vld[SlotRecord] = r.vld;
      slot_res[SlotRecord] = r.res;
      if (!st.header_complete) begin
        slot_vld[SlotDefault] = 1'b1;
        slot_res[SlotDefault] = make_res(KindDefaultHeader, '0, '0, 1'b1, '0,
                                         st.overflow_seen);
      end
      st = '0;
    end
    state_d = accept ? st : state_q;
  end

  assign push_o         = accept && (|slot_vld);
  assign bundle_o.mask  = slot_vld;
  assign bundle_o.slots = slot_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      sep_q   <= SepComma;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) sep_q <= cfg_i.separator_select;
    end
  end

endmodule

// ===== hdl/csv_tok_queue.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer bundle queue
// Short first-in first-out queue of result bundles between front and back end.
// ----------------------------------------------------------------------------
module csv_tok_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  csv_tok_pkg::bundle_t push_data_i,
  output logic                 push_ready_o,
  input  logic                 pop_i,
  output logic                 pop_valid_o,
  output csv_tok_pkg::bundle_t pop_data_o
);
  import csv_tok_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  bundle_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            wr_en, rd_en;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign wr_en        = push_i && push_ready_o;
  assign rd_en        = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (rd_en) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (wr_en && !rd_en) count_q <= count_q + CntW'(1);
      else if (rd_en && !wr_en) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// ===== hdl/csv_tok_back.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer back end
// Holds one bundle and hands its results out in order, flagging the last one.
// ----------------------------------------------------------------------------
module csv_tok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  input  csv_tok_pkg::bundle_t pop_data_i,
  output logic                 pop_o,
  csv_tok_result_if.source     result_o
);
  import csv_tok_pkg::*;

  logic [NumSlots-1:0] mask_q;
  res_t [NumSlots-1:0] slots_q;
  logic [NumSlots-1:0] sel_oh;
  logic [NumSlots-1:0] rest;
  logic                found;
  res_t                cur;
  logic                take;
  logic                load;

  always_comb begin
    sel_oh = '0;
    found  = 1'b0;
    cur    = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (mask_q[i] && !found) begin
        sel_oh[i] = 1'b1;
        found     = 1'b1;
        cur       = slots_q[i];
      end
    end
  end

  assign rest  = mask_q & ~sel_oh;
  assign take  = result_o.valid && result_o.ready;
  assign load  = pop_valid_i && ((mask_q == '0) || (take && (rest == '0)));
  assign pop_o = load;

  assign result_o.valid            = |mask_q;
  assign result_o.item_kind        = cur.kind;
  assign result_o.data_byte        = cur.data_byte;
  assign result_o.column           = cur.column;
  assign result_o.in_header        = cur.in_header;
  assign result_o.pad_fields       = cur.pad_fields;
  assign result_o.too_many_columns = cur.too_many;
  assign result_o.last             = (rest == '0);

  always_ff @(posedge clk_i) begin
    if (load) slots_q <= pop_data_i.slots;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load) begin
      mask_q <= pop_data_i.mask;
    end else if (take) begin
      mask_q <= rest;
    end
  end

endmodule

// ===== hdl/csv_record_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// CSV record tokenizer unit: results pass the bundle queue, then the back-end register.
// Throughput one request per cycle while the queue has room; results leave one by one.
// Four-bundle queue lets the front keep taking requests while the back drains.
// Reset clears parser state, queue and output; separator returns to comma.
// ----------------------------------------------------------------------------
`include "csv_record_tokenizer_unit_assert.svh"

module csv_record_tokenizer_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  csv_tok_text_if.sink     text_i,
  csv_tok_cfg_if.sink      cfg_i,
  csv_tok_result_if.source result_o
);
  import csv_tok_pkg::*;

  logic    push;
  logic    push_ready;
  logic    pop;
  logic    pop_valid;
  bundle_t push_data;
  bundle_t pop_data;

  csv_tok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .cfg_i        (cfg_i),
    .push_o       (push),
    .bundle_o     (push_data),
    .push_ready_i (push_ready)
  );

  csv_tok_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  csv_tok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .result_o    (result_o)
  );

  `CSV_ASSERT(a_default_hdr_final, (result_o.valid && result_o.item_kind == KindDefaultHeader) |-> (result_o.last && result_o.in_header && !result_o.too_many_columns), "default header not final")
  `CSV_ASSERT(a_pad_on_record_end, (result_o.valid && result_o.item_kind != KindRecordEnd) |-> (result_o.pad_fields == '0), "padding outside record end")
  `CSV_ASSERT(a_push_when_room, push |-> push_ready, "bundle pushed into full queue")
  `CSV_ASSERT_RST(a_quiet_in_reset, !rst_ni |-> !result_o.valid, "result valid during reset")

endmodule

// ===== test/csv_record_tokenizer_unit_test.sv =====
// ----------------------------------------------------------------------------
// CSV record tokenizer unit testbench
// Streams CSV text through the unit under several separator settings and
// predicts every token it should return. The text covers byte order marks,
// quoting, blank lines, rows of uneven width, over-wide headers and noise.
// Each returned token is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_unit_test;
  import csv_tok_pkg::*;

  localparam int          SettleCycles   = 16;
  localparam int          CycleLimit     = 400000;
  localparam int          RandomRequests = 470;
  localparam int          NumPhases      = 5;
  localparam int          TailRequests   = 60;
  localparam int          MaxTokens      = 4;
  localparam int          PrintLimit     = 40;
  localparam logic [1:0]  SepUnused      = 2'd3;
  localparam logic [23:0] BomMark        = 24'hEFBBBF;

  typedef enum logic [1:0] {
    EntryText,
    EntryConfig,
    EntryPause
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        end_of_text;
    logic [1:0]  sep_code;
    int          gap;
  } stimulus_t;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data_byte;
    logic [5:0] column;
    logic       in_header;
    logic [5:0] pad_fields;
    logic       too_many;
    logic       last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  csv_tok_text_if   text_if ();
  csv_tok_cfg_if    cfg_if ();
  csv_tok_result_if result_if ();

  csv_record_tokenizer_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  always #5 clk_i = ~clk_i;

  stimulus_t stimulus_queue[$];
  token_t    step_tokens[$];
  token_t    expected_tokens[$];

  int requests_queued = 0;
  int requests_done   = 0;
  int configs_done    = 0;
  int tokens_checked  = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int quiet_cycles    = 0;
  int stall_left      = 0;
  int calm_left       = 0;
  int idle_pct        = 0;

  logic [1:0] sep_sel;
  logic       in_quotes, quote_pend, line_content, bom_done, hdr_done, overflow;
  logic [1:0] bom_held;
  logic [6:0] field_idx, hdr_width;

  function automatic logic [7:0] separator_byte(logic [1:0] code);
    case (code)
      SepSemicolon: return SemicolonByte;
      SepTab:       return TabByte;
      default:      return CommaByte;
    endcase
  endfunction

  function automatic logic [7:0] mark_byte(int idx);
    return BomMark[23 - 8 * idx -: 8];
  endfunction

  function automatic logic [6:0] column_limit();
    return hdr_done ? hdr_width : 7'(MaxColumns);
  endfunction

  task automatic clear_parser();
    in_quotes    = 1'b0;
    quote_pend   = 1'b0;
    line_content = 1'b0;
    bom_held     = '0;
    bom_done     = 1'b0;
    field_idx    = '0;
    hdr_width    = '0;
    hdr_done     = 1'b0;
    overflow     = 1'b0;
  endtask

  task automatic emit_token(item_kind_e kind, logic [7:0] b, logic [6:0] col, logic hdr,
                            logic [6:0] pad);
    token_t t;
    if (step_tokens.size() < MaxTokens) begin
      t.kind       = kind;
      t.data_byte  = b;
      t.column     = col[5:0];
      t.in_header  = hdr;
      t.pad_fields = pad[5:0];
      t.too_many   = overflow;
      t.last       = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
    end
  endtask

  task automatic field_char(logic [7:0] b);
    if (field_idx < column_limit()) emit_token(KindData, b, field_idx, !hdr_done, '0);
  endtask

  task automatic close_record();
    logic [6:0] lim;
    logic [6:0] col;
    lim = column_limit();
    col = (field_idx < lim) ? field_idx : lim - 7'd1;
    if (line_content) begin
      if (!hdr_done) begin
        hdr_width = col + 7'd1;
        hdr_done  = 1'b1;
        emit_token(KindRecordEnd, '0, col, 1'b1, '0);
      end else begin
        emit_token(KindRecordEnd, '0, col, 1'b0, hdr_width - 7'd1 - col);
      end
    end
    field_idx    = '0;
    line_content = 1'b0;
  endtask

  task automatic parse_char(logic [7:0] b);
    logic [7:0] sep;
    logic [6:0] lim;
    logic       open;
    sep  = separator_byte(sep_sel);
    open = 1'b1;
    if (quote_pend) begin
      quote_pend = 1'b0;
      if (b == QuoteByte) begin
        field_char(QuoteByte);
        open = 1'b0;
      end else begin
        in_quotes = 1'b0;
      end
    end else if (in_quotes) begin
      open = 1'b0;
      if (b == QuoteByte) quote_pend = 1'b1;
      else field_char(b);
    end
    if (open) begin
      if (b == QuoteByte) begin
        in_quotes    = 1'b1;
        line_content = 1'b1;
      end else if (b == sep) begin
        lim = column_limit();
        if (field_idx + 7'd1 < lim) begin
          emit_token(KindFieldEnd, '0, field_idx, !hdr_done, '0);
          field_idx = field_idx + 7'd1;
        end else begin
          if (!hdr_done) overflow = 1'b1;
          field_idx = lim;
        end
        line_content = 1'b1;
      end else if (b == LfByte) begin
        close_record();
      end else if (b != CrByte) begin
        field_char(b);
        line_content = 1'b1;
      end
    end
  endtask

  task automatic replay_mark_bytes();
    int n;
    n        = bom_held;
    bom_held = '0;
    bom_done = 1'b1;
    for (int i = 0; i < n; i++) parse_char(mark_byte(i));
  endtask

  task automatic tokenize_text(logic [7:0] b, logic has, logic eot);
    token_t t;
    step_tokens.delete();
    if (has) begin
      if (!bom_done && b == mark_byte(bom_held)) begin
        if (bom_held == 2'd2) begin
          bom_held = '0;
          bom_done = 1'b1;
        end else begin
          bom_held = bom_held + 2'd1;
        end
      end else begin
        if (!bom_done) replay_mark_bytes();
        parse_char(b);
      end
    end
    if (eot) begin
      if (!bom_done) replay_mark_bytes();
      if (quote_pend) begin
        quote_pend = 1'b0;
        in_quotes  = 1'b0;
      end
      close_record();
      if (!hdr_done) emit_token(KindDefaultHeader, '0, '0, 1'b1, '0);
      clear_parser();
    end
    foreach (step_tokens[i]) begin
      t      = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  task automatic report_mismatch(string what, int got_v, int want_v);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("[%0d] token %0d %s: got %0d, expected %0d", cycle_count, tokens_checked, what,
               got_v, want_v);
  endtask

  function automatic int next_gap();
    return ($urandom_range(99) < idle_pct) ? $urandom_range(1, 15) : 0;
  endfunction

  task automatic push_text(logic [7:0] b, logic has, logic eot);
    stimulus_t s;
    s.kind        = EntryText;
    s.text_byte   = b;
    s.has_byte    = has;
    s.end_of_text = eot;
    s.sep_code    = '0;
    s.gap         = next_gap();
    stimulus_queue.insert(stimulus_queue.size(), s);
    if (has || eot) requests_queued++;
  endtask

  task automatic push_control(entry_kind_e kind, logic [1:0] code);
    stimulus_t s;
    s.kind        = kind;
    s.text_byte   = '0;
    s.has_byte    = 1'b0;
    s.end_of_text = 1'b0;
    s.sep_code    = code;
    s.gap         = next_gap();
    stimulus_queue.insert(stimulus_queue.size(), s);
  endtask

  task automatic push_string(string str);
    for (int i = 0; i < str.len(); i++) push_text(str[i], 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] plain_byte(logic [7:0] sep);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == QuoteByte || b == CrByte || b == LfByte || b == sep);
    return b;
  endfunction

  task automatic push_field(logic [7:0] sep, int max_len);
    int         style;
    int         n;
    logic [7:0] b;
    style = $urandom_range(9);
    n     = $urandom_range(1, (max_len < 1) ? 1 : max_len);
    if (max_len == 0) begin
      if ($urandom_range(3) == 0) push_text(plain_byte(sep), 1'b1, 1'b0);
    end else if (style >= 2 && style < 7) begin
      repeat (n) push_text(plain_byte(sep), 1'b1, 1'b0);
    end else if (style >= 7) begin
      push_text(QuoteByte, 1'b1, 1'b0);
      repeat (n) begin
        case ($urandom_range(7))
          0:       b = QuoteByte;
          1:       b = sep;
          2:       b = LfByte;
          3:       b = CrByte;
          default: b = 8'($urandom_range(255));
        endcase
        push_text(b, 1'b1, 1'b0);
        if (b == QuoteByte) push_text(QuoteByte, 1'b1, 1'b0);
      end
      push_text(QuoteByte, 1'b1, 1'b0);
    end
    if ($urandom_range(39) == 0) push_text(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic push_record(logic [7:0] sep, int ncols, int max_len, logic crlf,
                             logic terminate);
    for (int c = 0; c < ncols; c++) begin
      if (c > 0) push_text(sep, 1'b1, 1'b0);
      push_field(sep, max_len);
    end
    if (terminate) begin
      if (crlf) push_text(CrByte, 1'b1, 1'b0);
      push_text(LfByte, 1'b1, 1'b0);
    end
  endtask

  task automatic push_table(logic [7:0] sep, logic wide);
    int        hdr_cols;
    int        rows;
    int        cols;
    logic      crlf;
    stimulus_t s;
    case ($urandom_range(5))
      0: begin
        push_text(mark_byte(0), 1'b1, 1'b0);
        push_text(mark_byte(1), 1'b1, 1'b0);
        push_text(mark_byte(2), 1'b1, 1'b0);
      end
      1: begin
        push_text(mark_byte(0), 1'b1, 1'b0);
        if ($urandom_range(1)) push_text(mark_byte(1), 1'b1, 1'b0);
      end
      default: ;
    endcase
    hdr_cols = wide ? MaxColumns - 1 + $urandom_range(4) : $urandom_range(1, 6);
    rows     = wide ? 1 : $urandom_range(0, 4);
    crlf     = 1'($urandom_range(1));
    for (int r = 0; r <= rows; r++) begin
      if ($urandom_range(7) == 0) push_text(LfByte, 1'b1, 1'b0);
      if (r == 0) cols = hdr_cols;
      else if (wide) cols = $urandom_range(hdr_cols - 3, hdr_cols + 3);
      else cols = $urandom_range(1, hdr_cols + 2);
      push_record(sep, cols, wide ? 0 : 3, crlf, (r < rows) || $urandom_range(1));
    end
    case ($urandom_range(3))
      0: begin
        s             = stimulus_queue[$];
        s.end_of_text = 1'b1;
        stimulus_queue[$] = s;
      end
      1: begin
        push_text(QuoteByte, 1'b1, 1'b0);
        push_text(plain_byte(sep), 1'b1, 1'b1);
      end
      default: push_text(8'($urandom_range(255)), 1'b0, 1'b1);
    endcase
  endtask

  // driver: one request in flight, gaps and pauses taken from the head entry
  always @(posedge clk_i) begin : drive
    stimulus_t head;
    logic      nx_text;
    logic      nx_cfg;
    if (rst_ni) begin
      nx_text = text_if.valid;
      nx_cfg  = cfg_if.valid;
      if (text_if.valid && text_if.ready) begin
        head = stimulus_queue.pop_front();
        tokenize_text(head.text_byte, head.has_byte, head.end_of_text);
        if (head.has_byte || head.end_of_text) requests_done++;
        nx_text = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        head    = stimulus_queue.pop_front();
        sep_sel = head.sep_code;
        configs_done++;
        nx_cfg  = 1'b0;
      end
      quiet_cycles = (expected_tokens.size() == 0) ? quiet_cycles + 1 : 0;
      if (!nx_text && !nx_cfg && stimulus_queue.size() > 0) begin
        head = stimulus_queue[0];
        if (head.gap > 0) begin
          head.gap--;
          stimulus_queue[0] = head;
        end else begin
          case (head.kind)
            EntryText: begin
              nx_text              = 1'b1;
              text_if.text_byte   <= head.text_byte;
              text_if.has_byte    <= head.has_byte;
              text_if.end_of_text <= head.end_of_text;
            end
            EntryConfig: begin
              if (quiet_cycles >= SettleCycles) begin
                nx_cfg                   = 1'b1;
                cfg_if.separator_select <= head.sep_code;
              end
            end
            default: begin
              if (quiet_cycles >= SettleCycles) void'(stimulus_queue.pop_front());
            end
          endcase
        end
      end
      text_if.valid <= nx_text;
      cfg_if.valid  <= nx_cfg;
    end
  end

  // monitor: compare each returned token, stall the result side in bursts
  always @(posedge clk_i) begin : observe
    token_t got;
    token_t want;
    logic   nx_ready;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got.kind       = item_kind_e'(result_if.item_kind);
        got.data_byte  = result_if.data_byte;
        got.column     = result_if.column;
        got.in_header  = result_if.in_header;
        got.pad_fields = result_if.pad_fields;
        got.too_many   = result_if.too_many_columns;
        got.last       = result_if.last;
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token, kind", got.kind, -1);
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind) report_mismatch("item_kind", got.kind, want.kind);
          if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
          if (got.column !== want.column) report_mismatch("column", got.column, want.column);
          if (got.in_header !== want.in_header)
            report_mismatch("in_header", got.in_header, want.in_header);
          if (got.pad_fields !== want.pad_fields)
            report_mismatch("pad_fields", got.pad_fields, want.pad_fields);
          if (got.too_many !== want.too_many)
            report_mismatch("too_many_columns", got.too_many, want.too_many);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        end
        tokens_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        nx_ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        nx_ready = 1'b1;
      end else if (stimulus_queue.size() <= TailRequests) begin
        nx_ready = 1'b1;
      end else if ($urandom_range(7) == 0) begin
        stall_left = $urandom_range(0, 14);
        nx_ready   = 1'b0;
      end else begin
        nx_ready = 1'b1;
        if ($urandom_range(31) == 0) calm_left = $urandom_range(20, 100);
      end
      result_if.ready <= nx_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d tokens outstanding",
               expected_tokens.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         target;
    logic [1:0] phase_sep;
    stimulus_t  s;
    rst_ni                  = 1'b1;
    text_if.valid           = 1'b0;
    text_if.text_byte       = '0;
    text_if.has_byte        = 1'b0;
    text_if.end_of_text     = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.separator_select = '0;
    result_if.ready         = 1'b0;
    sep_sel                 = SepComma;
    clear_parser();
    #1 rst_ni = 1'b0;

    idle_pct = 20;
    push_control(EntryConfig, SepUnused);
    push_text(8'h00, 1'b0, 1'b1);
    push_text(mark_byte(0), 1'b1, 1'b0);
    push_text(mark_byte(1), 1'b1, 1'b0);
    push_text(mark_byte(2), 1'b1, 1'b0);
    push_string("\"x\"\"\",");
    push_text(8'h00, 1'b1, 1'b0);
    push_text(CrByte, 1'b1, 1'b0);
    push_text(LfByte, 1'b1, 1'b0);
    push_text(LfByte, 1'b1, 1'b0);
    push_text(8'hFF, 1'b0, 1'b0);
    push_text(8'hFF, 1'b1, 1'b0);
    push_text(QuoteByte, 1'b1, 1'b1);
    push_text(mark_byte(0), 1'b1, 1'b0);
    push_text(mark_byte(1), 1'b1, 1'b0);
    push_text(8'h7F, 1'b0, 1'b1);
    push_text(mark_byte(0), 1'b1, 1'b0);
    push_text(8'h41, 1'b1, 1'b1);
    push_string("\"q");
    push_text(QuoteByte, 1'b1, 1'b1);
    push_control(EntryPause, '0);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       phase_sep = SepSemicolon;
        1:       phase_sep = SepTab;
        2:       phase_sep = SepComma;
        default: phase_sep = 2'($urandom_range(3));
      endcase
      push_control(EntryConfig, phase_sep);
      target = requests_queued + RandomRequests / NumPhases;
      if (p == 1) push_table(separator_byte(phase_sep), 1'b1);
      while (requests_queued < target) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(4, 14))
            push_text(8'($urandom_range(255)), $urandom_range(3) != 0,
                      $urandom_range(9) == 0);
        end else begin
          push_table(separator_byte(phase_sep), 1'b0);
        end
        if ($urandom_range(7) == 0) push_control(EntryPause, '0);
      end
    end
    for (int i = stimulus_queue.size() - TailRequests; i < stimulus_queue.size(); i++) begin
      s     = stimulus_queue[i];
      s.gap = 0;
      stimulus_queue[i] = s;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus_queue.size() != 0 || expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Streamed %0d text requests under %0d separator writes, %0d tokens compared",
             requests_done, configs_done, tokens_checked);
    $display("Mismatching fields: %0d", mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== csv_record_tokenizer_unit.f =====
+incdir+hdl
hdl/csv_tok_pkg.sv
hdl/csv_tok_if.sv
hdl/csv_tok_front.sv
hdl/csv_tok_queue.sv
hdl/csv_tok_back.sv
hdl/csv_record_tokenizer_unit.sv
test/csv_record_tokenizer_unit_test.sv
